// ----- hw/rtl/ffca_pkg.sv -----
// Shared types, codes and constants of the first-fit coalescing allocator.
`timescale 1ns / 1ps

package ffca_pkg;

  // Field widths.
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned ALIGN_W    = 16;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;

  // Default number of chunk descriptors.
  localparam int unsigned DEFAULT_MAX_CHUNKS = 64;

  // Smallest alignment that the allocator works with.
  localparam logic [ALIGN_W-1:0] MIN_ALIGN = ALIGN_W'(2);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID_AREA = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_UNIT  = 2'd2;

  // Request transaction.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] release_address;
  } req_t;

  // Response transaction.
  typedef struct packed {
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

// ----- hw/rtl/ffca_rem.sv -----
// Bit-serial remainder unit: dividend modulo a narrow divisor, one bit per cycle.
`timescale 1ns / 1ps

module ffca_rem (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [ffca_pkg::ADDR_W-1:0]      dividend_i,
  input  logic [ffca_pkg::ALIGN_W-1:0]     divisor_i,
  output logic                             done_o,
  output logic [ffca_pkg::ALIGN_W-1:0]     rem_o
);

  localparam int unsigned DW = ffca_pkg::ADDR_W;
  localparam int unsigned VW = ffca_pkg::ALIGN_W;
  localparam int unsigned CW = $clog2(DW);

  logic [DW-1:0] dvd_q;
  logic [VW-1:0] dvs_q;
  logic [VW-1:0] r_q;
  logic [VW-1:0] r_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [VW:0]   trial;

  // One restoring step: shift in the next dividend bit and subtract if it fits.
  always_comb begin
    trial = {r_q, dvd_q[DW-1]};
    if (trial >= {1'b0, dvs_q}) begin
      r_d = VW'(trial - {1'b0, dvs_q});
    end else begin
      r_d = trial[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      r_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      dvd_q  <= dividend_i;
      dvs_q  <= divisor_i;
      r_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      r_q   <= r_d;
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// ----- hw/rtl/ffca_mem.sv -----
// Descriptor memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module ffca_mem #(
  parameter int unsigned DEPTH = ffca_pkg::DEFAULT_MAX_CHUNKS,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data is registered and appears in the cycle after the read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/first_fit_coalescing_allocator_core.sv -----
// First-fit allocator core: one operation at a time, result in a registered output.
// Init computes two bit-serial remainders, of the area start and end, then trims inward.
// Allocate rounds the size up with a bit-serial remainder, walks the free list and splits
// a larger chunk; an exact fit walks the free list again to unlink it.
// Free scans the descriptors by start address and reads only the in-use ones; each merge
// walks the free list to unlink a chunk. The next transaction is taken after the result.
// Reset clears the in-use and free flags and the free-list head; there is no clearing pass.
`timescale 1ns / 1ps

module first_fit_coalescing_allocator_core #(
  parameter int unsigned MAX_CHUNKS = ffca_pkg::DEFAULT_MAX_CHUNKS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ffca_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ffca_pkg::ADDR_W-1:0]        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ffca_pkg::req_t                     in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ffca_pkg::rsp_t                     out_data_o
);

  localparam int unsigned AW = ffca_pkg::ADDR_W;
  localparam int unsigned VW = ffca_pkg::ALIGN_W;
  localparam int unsigned IW = $clog2(MAX_CHUNKS);
  localparam int unsigned LW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned EW = 2 * AW + 3 * LW;
  localparam logic [LW-1:0] NIL = LW'(MAX_CHUNKS);

  // State codes.
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DONE    = 5'd1;
  localparam logic [4:0] S_I_R1    = 5'd2;
  localparam logic [4:0] S_I_R2    = 5'd3;
  localparam logic [4:0] S_I_CHK   = 5'd4;
  localparam logic [4:0] S_A_REM   = 5'd5;
  localparam logic [4:0] S_A_WRD   = 5'd6;
  localparam logic [4:0] S_A_WCHK  = 5'd7;
  localparam logic [4:0] S_A_FIT   = 5'd8;
  localparam logic [4:0] S_A_SPARE = 5'd9;
  localparam logic [4:0] S_F_SRD   = 5'd10;
  localparam logic [4:0] S_F_SCHK  = 5'd11;
  localparam logic [4:0] S_F_K     = 5'd12;
  localparam logic [4:0] S_F_S     = 5'd13;
  localparam logic [4:0] S_F_SGET  = 5'd14;
  localparam logic [4:0] S_F_SAR   = 5'd15;
  localparam logic [4:0] S_F_P     = 5'd16;
  localparam logic [4:0] S_F_PGET  = 5'd17;
  localparam logic [4:0] S_F_PRM   = 5'd18;
  localparam logic [4:0] S_F_KAR   = 5'd19;
  localparam logic [4:0] S_RM_RD   = 5'd20;
  localparam logic [4:0] S_RM_CHK  = 5'd21;
  localparam logic [4:0] S_RM_WP   = 5'd22;
  localparam logic [4:0] S_RM_WC   = 5'd23;
  localparam logic [4:0] S_AR_RD   = 5'd24;
  localparam logic [4:0] S_AR_GET  = 5'd25;
  localparam logic [4:0] S_AR_P    = 5'd26;
  localparam logic [4:0] S_AR_N    = 5'd27;
  localparam logic [4:0] S_AR_END  = 5'd28;
  localparam logic [4:0] S_MW_RD   = 5'd29;
  localparam logic [4:0] S_MW_WR   = 5'd30;

  // Field update kinds of the read-modify-write helper.
  localparam logic [1:0] MW_ANEXT = 2'd0;
  localparam logic [1:0] MW_APREV = 2'd1;
  localparam logic [1:0] MW_ADD   = 2'd2;

  // Descriptor field access: {start, length, free next, address prev, address next}.
  function automatic logic [AW-1:0] f_start(input logic [EW-1:0] x);
    return x[EW-1 -: AW];
  endfunction
  function automatic logic [AW-1:0] f_len(input logic [EW-1:0] x);
    return x[EW-AW-1 -: AW];
  endfunction
  function automatic logic [LW-1:0] f_fn(input logic [EW-1:0] x);
    return x[3*LW-1 -: LW];
  endfunction
  function automatic logic [LW-1:0] f_ap(input logic [EW-1:0] x);
    return x[2*LW-1 -: LW];
  endfunction
  function automatic logic [LW-1:0] f_an(input logic [EW-1:0] x);
    return x[LW-1:0];
  endfunction
  function automatic logic [EW-1:0] mk(input logic [AW-1:0] st, input logic [AW-1:0] ln,
                                       input logic [LW-1:0] fn, input logic [LW-1:0] ap,
                                       input logic [LW-1:0] an);
    return {st, ln, fn, ap, an};
  endfunction
  function automatic logic lv(input logic [LW-1:0] x);
    return x < LW'(MAX_CHUNKS);
  endfunction
  function automatic logic [IW-1:0] li(input logic [LW-1:0] x);
    return x[IW-1:0];
  endfunction

  // Registers.
  logic [4:0]            state_q, state_d;
  logic [4:0]            rm_ret_q, rm_ret_d;
  logic [4:0]            ar_ret_q, ar_ret_d;
  logic [4:0]            mw_ret_q, mw_ret_d;
  logic [AW-1:0]         arg_q, arg_d;
  logic [AW-1:0]         res_addr_q, res_addr_d;
  logic [2:0]            res_st_q, res_st_d;
  logic                  out_valid_q, out_valid_d;
  ffca_pkg::rsp_t        out_q, out_d;
  logic [AW-1:0]         area_start_q;
  logic [AW-1:0]         area_length_q;
  logic [VW-1:0]         align_unit_q;
  logic [VW-1:0]         lalign_q, lalign_d;
  logic [MAX_CHUNKS-1:0] in_use_q, in_use_d;
  logic [MAX_CHUNKS-1:0] is_free_q, is_free_d;
  logic [LW-1:0]         head_q, head_d;
  logic [VW-1:0]         exb_q, exb_d;
  logic [VW-1:0]         exe_q, exe_d;
  logic [AW-1:0]         asz_q, asz_d;
  logic [LW-1:0]         cur_q, cur_d;
  logic [LW-1:0]         cnt_q, cnt_d;
  logic [EW-1:0]         kent_q, kent_d;
  logic [IW-1:0]         k_q, k_d;
  logic [IW-1:0]         s_q, s_d;
  logic [IW-1:0]         sp_q, sp_d;
  logic [IW-1:0]         rm_tgt_q, rm_tgt_d;
  logic [LW-1:0]         rm_cur_q, rm_cur_d;
  logic [LW-1:0]         rm_prev_q, rm_prev_d;
  logic [LW-1:0]         rm_cnt_q, rm_cnt_d;
  logic [EW-1:0]         pv_q, pv_d;
  logic [EW-1:0]         cu_q, cu_d;
  logic [IW-1:0]         ar_tgt_q, ar_tgt_d;
  logic [LW-1:0]         ar_p_q, ar_p_d;
  logic [LW-1:0]         ar_nx_q, ar_nx_d;
  logic [IW-1:0]         mw_idx_q, mw_idx_d;
  logic [1:0]            mw_sel_q, mw_sel_d;
  logic [AW-1:0]         mw_val_q, mw_val_d;

  // Memory and remainder unit connections.
  logic                  mem_re, mem_we;
  logic [IW-1:0]         mem_raddr, mem_waddr;
  logic [EW-1:0]         mem_wdata, mem_rdata;
  logic                  rem_start, rem_done;
  logic [AW-1:0]         rem_dvd;
  logic [VW-1:0]         rem_dvs, rem_val;

  // Derived values.
  logic [VW-1:0]         a_eff;
  logic [AW-1:0]         area_end;
  logic                  spare_ok;
  logic [IW-1:0]         spare_idx;

  assign a_eff    = (align_unit_q < ffca_pkg::MIN_ALIGN) ? ffca_pkg::MIN_ALIGN : align_unit_q;
  assign area_end = area_start_q + area_length_q;

  // Lowest descriptor that holds no chunk.
  always_comb begin
    spare_ok  = 1'b0;
    spare_idx = '0;
    for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        spare_ok  = 1'b1;
        spare_idx = IW'(i);
      end
    end
  end

  ffca_mem #(
    .DEPTH (MAX_CHUNKS),
    .WIDTH (EW),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ffca_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .divisor_i  (rem_dvs),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  // Operation sequencer.
  always_comb begin
    logic [AW:0]   sum;
    logic [AW-1:0] rnd;
    logic [AW-1:0] ab;
    logic [AW-1:0] ae;
    logic [AW-1:0] rest;
    logic [LW-1:0] lk;

    sum  = '0;
    rnd  = '0;
    ab   = '0;
    ae   = '0;
    rest = '0;
    lk   = '0;

    state_d     = state_q;
    rm_ret_d    = rm_ret_q;
    ar_ret_d    = ar_ret_q;
    mw_ret_d    = mw_ret_q;
    arg_d       = arg_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    lalign_d    = lalign_q;
    in_use_d    = in_use_q;
    is_free_d   = is_free_q;
    head_d      = head_q;
    exb_d       = exb_q;
    exe_d       = exe_q;
    asz_d       = asz_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    kent_d      = kent_q;
    k_d         = k_q;
    s_d         = s_q;
    sp_d        = sp_q;
    rm_tgt_d    = rm_tgt_q;
    rm_cur_d    = rm_cur_q;
    rm_prev_d   = rm_prev_q;
    rm_cnt_d    = rm_cnt_q;
    pv_d        = pv_q;
    cu_d        = cu_q;
    ar_tgt_d    = ar_tgt_q;
    ar_p_d      = ar_p_q;
    ar_nx_d     = ar_nx_q;
    mw_idx_d    = mw_idx_q;
    mw_sel_d    = mw_sel_q;
    mw_val_d    = mw_val_q;

    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    rem_start = 1'b0;
    rem_dvd   = area_start_q;
    rem_dvs   = a_eff;

    // The output register empties when its transaction is taken.
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_addr_d = '0;
          res_st_d   = ffca_pkg::ST_OK;
          case (in_data_i.op)
            ffca_pkg::OP_INIT: begin
              rem_start = 1'b1;
              state_d   = S_I_R1;
            end
            ffca_pkg::OP_ALLOC: begin
              arg_d     = in_data_i.request_size;
              rem_start = 1'b1;
              rem_dvd   = in_data_i.request_size;
              rem_dvs   = lalign_q;
              state_d   = S_A_REM;
            end
            ffca_pkg::OP_FREE: begin
              arg_d = in_data_i.release_address;
              cur_d = '0;
              if (in_data_i.release_address == '0) begin
                state_d = S_DONE;
              end else begin
                state_d = S_F_SRD;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Initialise: remainders of start and end, then trim inward.
      S_I_R1: begin
        if (rem_done) begin
          exb_d     = rem_val;
          rem_start = 1'b1;
          rem_dvd   = area_end;
          state_d   = S_I_R2;
        end
      end
      S_I_R2: begin
        if (rem_done) begin
          exe_d   = rem_val;
          state_d = S_I_CHK;
        end
      end
      S_I_CHK: begin
        sum = {1'b0, area_start_q} + {{(AW + 1 - VW){1'b0}}, a_eff - exb_q};
        ab  = (exb_q != '0) ? sum[AW-1:0] : area_start_q;
        ae  = area_end - AW'(exe_q);
        if (area_start_q < area_end && area_start_q <= ab && ab < ae) begin
          in_use_d     = '0;
          is_free_d    = '0;
          in_use_d[0]  = 1'b1;
          is_free_d[0] = 1'b1;
          head_d       = '0;
          lalign_d     = a_eff;
          mem_we       = 1'b1;
          mem_waddr    = '0;
          mem_wdata    = mk(ab, ae - ab, NIL, NIL, NIL);
        end else begin
          res_st_d = ffca_pkg::ST_INVALID_AREA;
        end
        state_d = S_DONE;
      end

      // Allocate: round the size up, then walk the free list.
      S_A_REM: begin
        if (rem_done) begin
          sum   = {1'b0, arg_q} + {{(AW + 1 - VW){1'b0}}, lalign_q - rem_val};
          rnd   = (rem_val != '0) ? sum[AW-1:0] : arg_q;
          asz_d = rnd;
          cur_d = head_q;
          cnt_d = '0;
          if (arg_q != '0 && arg_q <= rnd) begin
            state_d = S_A_WRD;
          end else begin
            res_st_d = ffca_pkg::ST_NO_MEMORY;
            state_d  = S_DONE;
          end
        end
      end
      S_A_WRD: begin
        if (cnt_q < LW'(MAX_CHUNKS) && lv(cur_q)) begin
          mem_re    = 1'b1;
          mem_raddr = li(cur_q);
          state_d   = S_A_WCHK;
        end else begin
          res_st_d = ffca_pkg::ST_NO_MEMORY;
          state_d  = S_DONE;
        end
      end
      S_A_WCHK: begin
        if (f_len(mem_rdata) >= asz_q) begin
          kent_d  = mem_rdata;
          k_d     = li(cur_q);
          state_d = S_A_FIT;
        end else begin
          cur_d   = f_fn(mem_rdata);
          cnt_d   = cnt_q + LW'(1);
          state_d = S_A_WRD;
        end
      end
      S_A_FIT: begin
        rest = f_len(kent_q) - asz_q;
        if (f_len(kent_q) > asz_q) begin
          if (spare_ok) begin
            // Shrink the found chunk and link the spare in after it.
            sp_d       = spare_idx;
            res_addr_d = f_start(kent_q) + rest;
            mem_we     = 1'b1;
            mem_waddr  = k_q;
            mem_wdata  = mk(f_start(kent_q), rest, f_fn(kent_q), f_ap(kent_q),
                            LW'(spare_idx));
            state_d    = S_A_SPARE;
          end else begin
            res_st_d = ffca_pkg::ST_NO_MEMORY;
            state_d  = S_DONE;
          end
        end else begin
          // Exact fit: take the chunk off the free list.
          res_addr_d = f_start(kent_q);
          rm_tgt_d   = k_q;
          rm_ret_d   = S_DONE;
          rm_cur_d   = head_q;
          rm_prev_d  = NIL;
          rm_cnt_d   = '0;
          state_d    = S_RM_RD;
        end
      end
      S_A_SPARE: begin
        lk            = f_an(kent_q);
        mem_we        = 1'b1;
        mem_waddr     = sp_q;
        mem_wdata     = mk(res_addr_q, asz_q, NIL, LW'(k_q), lk);
        in_use_d[sp_q]  = 1'b1;
        is_free_d[sp_q] = 1'b0;
        if (lv(lk)) begin
          mw_idx_d = li(lk);
          mw_sel_d = MW_APREV;
          mw_val_d = AW'(sp_q);
          mw_ret_d = S_DONE;
          state_d  = S_MW_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      // Free: look the chunk up by start address.
      S_F_SRD: begin
        if (!lv(cur_q)) begin
          res_st_d = ffca_pkg::ST_NOT_FOUND;
          state_d  = S_DONE;
        end else if (!in_use_q[li(cur_q)]) begin
          cur_d = cur_q + LW'(1);
        end else begin
          mem_re    = 1'b1;
          mem_raddr = li(cur_q);
          state_d   = S_F_SCHK;
        end
      end
      S_F_SCHK: begin
        if (mem_rdata[EW-1 -: AW-1] == arg_q[AW-1:1]) begin
          kent_d  = mem_rdata;
          k_d     = li(cur_q);
          state_d = S_F_K;
        end else begin
          cur_d   = cur_q + LW'(1);
          state_d = S_F_SRD;
        end
      end
      S_F_K: begin
        if (is_free_q[k_q]) begin
          res_st_d = ffca_pkg::ST_ALREADY_FREE;
          state_d  = S_DONE;
        end else begin
          // Push onto the head of the free list.
          kent_d         = mk(f_start(kent_q), f_len(kent_q), head_q, f_ap(kent_q),
                              f_an(kent_q));
          mem_we         = 1'b1;
          mem_waddr      = k_q;
          mem_wdata      = kent_d;
          head_d         = LW'(k_q);
          is_free_d[k_q] = 1'b1;
          state_d        = S_F_S;
        end
      end
      S_F_S: begin
        lk = f_an(kent_q);
        if (lv(lk) && is_free_q[li(lk)]) begin
          s_d       = li(lk);
          mem_re    = 1'b1;
          mem_raddr = li(lk);
          state_d   = S_F_SGET;
        end else begin
          state_d = S_F_P;
        end
      end
      S_F_SGET: begin
        // Absorb the free successor.
        kent_d    = mk(f_start(kent_q), f_len(kent_q) + f_len(mem_rdata), f_fn(kent_q),
                       f_ap(kent_q), f_an(kent_q));
        mem_we    = 1'b1;
        mem_waddr = k_q;
        mem_wdata = kent_d;
        rm_tgt_d  = s_q;
        rm_ret_d  = S_F_SAR;
        rm_cur_d  = head_q;
        rm_prev_d = NIL;
        rm_cnt_d  = '0;
        state_d   = S_RM_RD;
      end
      S_F_SAR: begin
        ar_tgt_d = s_q;
        ar_ret_d = S_F_P;
        state_d  = S_AR_RD;
      end
      S_F_P: begin
        mem_re    = 1'b1;
        mem_raddr = k_q;
        state_d   = S_F_PGET;
      end
      S_F_PGET: begin
        kent_d = mem_rdata;
        lk     = f_ap(mem_rdata);
        if (lv(lk) && is_free_q[li(lk)]) begin
          // Fold the chunk into its free predecessor.
          mw_idx_d = li(lk);
          mw_sel_d = MW_ADD;
          mw_val_d = f_len(mem_rdata);
          mw_ret_d = S_F_PRM;
          state_d  = S_MW_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F_PRM: begin
        rm_tgt_d  = k_q;
        rm_ret_d  = S_F_KAR;
        rm_cur_d  = head_q;
        rm_prev_d = NIL;
        rm_cnt_d  = '0;
        state_d   = S_RM_RD;
      end
      S_F_KAR: begin
        ar_tgt_d = k_q;
        ar_ret_d = S_DONE;
        state_d  = S_AR_RD;
      end

      // Free-list removal: walk from the head and unlink the target.
      S_RM_RD: begin
        if (rm_cnt_q < LW'(MAX_CHUNKS) && lv(rm_cur_q)) begin
          mem_re    = 1'b1;
          mem_raddr = li(rm_cur_q);
          state_d   = S_RM_CHK;
        end else begin
          is_free_d[rm_tgt_q] = 1'b0;
          state_d             = rm_ret_q;
        end
      end
      S_RM_CHK: begin
        if (li(rm_cur_q) == rm_tgt_q) begin
          cu_d = mem_rdata;
          if (lv(rm_prev_q)) begin
            state_d = S_RM_WP;
          end else begin
            head_d  = f_fn(mem_rdata);
            state_d = S_RM_WC;
          end
        end else begin
          rm_prev_d = rm_cur_q;
          pv_d      = mem_rdata;
          rm_cur_d  = f_fn(mem_rdata);
          rm_cnt_d  = rm_cnt_q + LW'(1);
          state_d   = S_RM_RD;
        end
      end
      S_RM_WP: begin
        mem_we    = 1'b1;
        mem_waddr = li(rm_prev_q);
        mem_wdata = mk(f_start(pv_q), f_len(pv_q), f_fn(cu_q), f_ap(pv_q), f_an(pv_q));
        state_d   = S_RM_WC;
      end
      S_RM_WC: begin
        mem_we              = 1'b1;
        mem_waddr           = li(rm_cur_q);
        mem_wdata           = mk(f_start(cu_q), f_len(cu_q), NIL, f_ap(cu_q), f_an(cu_q));
        is_free_d[rm_tgt_q] = 1'b0;
        state_d             = rm_ret_q;
      end

      // Address-order removal: bridge the neighbours and release the descriptor.
      S_AR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = ar_tgt_q;
        state_d   = S_AR_GET;
      end
      S_AR_GET: begin
        ar_p_d  = f_ap(mem_rdata);
        ar_nx_d = f_an(mem_rdata);
        state_d = S_AR_P;
      end
      S_AR_P: begin
        if (lv(ar_p_q)) begin
          mw_idx_d = li(ar_p_q);
          mw_sel_d = MW_ANEXT;
          mw_val_d = AW'(ar_nx_q);
          mw_ret_d = S_AR_N;
          state_d  = S_MW_RD;
        end else begin
          state_d = S_AR_N;
        end
      end
      S_AR_N: begin
        if (lv(ar_nx_q)) begin
          mw_idx_d = li(ar_nx_q);
          mw_sel_d = MW_APREV;
          mw_val_d = AW'(ar_p_q);
          mw_ret_d = S_AR_END;
          state_d  = S_MW_RD;
        end else begin
          state_d = S_AR_END;
        end
      end
      S_AR_END: begin
        in_use_d[ar_tgt_q]  = 1'b0;
        is_free_d[ar_tgt_q] = 1'b0;
        state_d             = ar_ret_q;
      end

      // Read-modify-write of one descriptor field.
      S_MW_RD: begin
        mem_re    = 1'b1;
        mem_raddr = mw_idx_q;
        state_d   = S_MW_WR;
      end
      S_MW_WR: begin
        mem_we    = 1'b1;
        mem_waddr = mw_idx_q;
        case (mw_sel_q)
          MW_ANEXT: mem_wdata = mk(f_start(mem_rdata), f_len(mem_rdata), f_fn(mem_rdata),
                                   f_ap(mem_rdata), mw_val_q[LW-1:0]);
          MW_APREV: mem_wdata = mk(f_start(mem_rdata), f_len(mem_rdata), f_fn(mem_rdata),
                                   mw_val_q[LW-1:0], f_an(mem_rdata));
          MW_ADD:   mem_wdata = mk(f_start(mem_rdata), f_len(mem_rdata) + mw_val_q,
                                   f_fn(mem_rdata), f_ap(mem_rdata), f_an(mem_rdata));
          default:  mem_wdata = mem_rdata;
        endcase
        state_d = mw_ret_q;
      end

      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_d.granted_address = res_addr_q;
          out_d.status          = res_st_q;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_start_q  <= '0;
      area_length_q <= '0;
      align_unit_q  <= ffca_pkg::MIN_ALIGN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ffca_pkg::CFG_AREA_START:  area_start_q  <= cfg_data_i;
        ffca_pkg::CFG_AREA_LENGTH: area_length_q <= cfg_data_i;
        ffca_pkg::CFG_ALIGN_UNIT:  align_unit_q  <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rm_ret_q    <= S_IDLE;
      ar_ret_q    <= S_IDLE;
      mw_ret_q    <= S_IDLE;
      arg_q       <= '0;
      res_addr_q  <= '0;
      res_st_q    <= ffca_pkg::ST_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      lalign_q    <= ffca_pkg::MIN_ALIGN;
      in_use_q    <= '0;
      is_free_q   <= '0;
      head_q      <= NIL;
      exb_q       <= '0;
      exe_q       <= '0;
      asz_q       <= '0;
      cur_q       <= '0;
      cnt_q       <= '0;
      kent_q      <= '0;
      k_q         <= '0;
      s_q         <= '0;
      sp_q        <= '0;
      rm_tgt_q    <= '0;
      rm_cur_q    <= NIL;
      rm_prev_q   <= NIL;
      rm_cnt_q    <= '0;
      pv_q        <= '0;
      cu_q        <= '0;
      ar_tgt_q    <= '0;
      ar_p_q      <= NIL;
      ar_nx_q     <= NIL;
      mw_idx_q    <= '0;
      mw_sel_q    <= MW_ANEXT;
      mw_val_q    <= '0;
    end else begin
      state_q     <= state_d;
      rm_ret_q    <= rm_ret_d;
      ar_ret_q    <= ar_ret_d;
      mw_ret_q    <= mw_ret_d;
      arg_q       <= arg_d;
      res_addr_q  <= res_addr_d;
      res_st_q    <= res_st_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      lalign_q    <= lalign_d;
      in_use_q    <= in_use_d;
      is_free_q   <= is_free_d;
      head_q      <= head_d;
      exb_q       <= exb_d;
      exe_q       <= exe_d;
      asz_q       <= asz_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      kent_q      <= kent_d;
      k_q         <= k_d;
      s_q         <= s_d;
      sp_q        <= sp_d;
      rm_tgt_q    <= rm_tgt_d;
      rm_cur_q    <= rm_cur_d;
      rm_prev_q   <= rm_prev_d;
      rm_cnt_q    <= rm_cnt_d;
      pv_q        <= pv_d;
      cu_q        <= cu_d;
      ar_tgt_q    <= ar_tgt_d;
      ar_p_q      <= ar_p_d;
      ar_nx_q     <= ar_nx_d;
      mw_idx_q    <= mw_idx_d;
      mw_sel_q    <= mw_sel_d;
      mw_val_q    <= mw_val_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the first-fit coalescing allocator core.
`timescale 1ns / 1ps

module tb;
  import ffca_pkg::*;

  localparam int NCHUNK   = 64;
  localparam int NIL      = NCHUNK;
  localparam int IDLE_CAP = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_AREA_START;
  logic [ADDR_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;

  first_fit_coalescing_allocator_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .in_data_i(in_data_i), .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the configuration registers and the chunk table.
  logic [31:0] reg_start, reg_length;
  logic [15:0] reg_align;
  logic [31:0] blk_base [NCHUNK];
  logic [31:0] blk_size [NCHUNK];
  bit          blk_used [NCHUNK];
  bit          blk_avail [NCHUNK];
  int          avail_next [NCHUNK];
  int          lo_nbr [NCHUNK];
  int          hi_nbr [NCHUNK];
  int          avail_head;
  logic [31:0] grain;

  rsp_t pending_rsp [$];
  int   mismatches = 0;
  int   idle_cycles = 0;

  function automatic logic [31:0] round_to_grain(logic [31:0] a, logic [31:0] v);
    logic [31:0] ex;
    ex = v % a;
    return (ex != 0) ? v + (a - ex) : v;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < NCHUNK; i++) begin
      blk_base[i] = '0;
      blk_size[i] = '0;
      blk_used[i] = 1'b0;
      blk_avail[i] = 1'b0;
      avail_next[i] = NIL;
      lo_nbr[i] = NIL;
      hi_nbr[i] = NIL;
    end
    avail_head = NIL;
  endfunction

  // Take chunk k off the free list, walking from the head.
  function automatic void unlink_avail(int k);
    int prv, cur;
    prv = NIL;
    cur = avail_head;
    for (int n = 0; n < NCHUNK && cur < NIL; n++) begin
      if (cur == k) begin
        if (prv < NIL) avail_next[prv] = avail_next[cur];
        else avail_head = avail_next[cur];
        avail_next[cur] = NIL;
        blk_avail[cur] = 1'b0;
        return;
      end
      prv = cur;
      cur = avail_next[cur];
    end
    blk_avail[k] = 1'b0;
  endfunction

  // Remove chunk k from address order and release its descriptor.
  function automatic void drop_block(int k);
    int p, nx;
    p = lo_nbr[k];
    nx = hi_nbr[k];
    if (p < NIL) hi_nbr[p] = nx;
    if (nx < NIL) lo_nbr[nx] = p;
    lo_nbr[k] = NIL;
    hi_nbr[k] = NIL;
    blk_used[k] = 1'b0;
    blk_avail[k] = 1'b0;
  endfunction

  function automatic logic [2:0] carve_region();
    logic [31:0] a, b, e, ab, ae;
    a = (reg_align < 2) ? 32'd2 : {16'd0, reg_align};
    b = reg_start;
    e = reg_start + reg_length;
    ab = round_to_grain(a, b);
    ae = e - (e % a);
    if (!(b < e && b <= ab && ab < ae)) return ST_INVALID_AREA;
    wipe_table();
    grain = a;
    blk_base[0] = ab;
    blk_size[0] = ae - ab;
    blk_used[0] = 1'b1;
    blk_avail[0] = 1'b1;
    avail_head = 0;
    return ST_OK;
  endfunction

  function automatic logic [2:0] grant_block(logic [31:0] size, output logic [31:0] addr);
    logic [31:0] asz, rest;
    int cur, found, spare, nx;
    addr = '0;
    asz = round_to_grain(grain, size);
    found = NIL;
    spare = NIL;
    if (!(size > 0 && size <= asz)) return ST_NO_MEMORY;
    cur = avail_head;
    for (int n = 0; n < NCHUNK && cur < NIL; n++) begin
      if (blk_size[cur] >= asz) begin
        found = cur;
        break;
      end
      cur = avail_next[cur];
    end
    if (found == NIL) return ST_NO_MEMORY;
    if (blk_size[found] > asz) begin
      rest = blk_size[found] - asz;
      for (int n = 0; n < NCHUNK; n++) begin
        if (!blk_used[n]) begin
          spare = n;
          break;
        end
      end
      if (spare == NIL) return ST_NO_MEMORY;
      blk_size[found] = rest;
      blk_base[spare] = blk_base[found] + rest;
      blk_size[spare] = asz;
      blk_used[spare] = 1'b1;
      blk_avail[spare] = 1'b0;
      avail_next[spare] = NIL;
      nx = hi_nbr[found];
      lo_nbr[spare] = found;
      hi_nbr[spare] = nx;
      hi_nbr[found] = spare;
      if (nx < NIL) lo_nbr[nx] = spare;
      addr = blk_base[spare];
    end else begin
      unlink_avail(found);
      addr = blk_base[found];
    end
    return ST_OK;
  endfunction

  function automatic logic [2:0] release_block(logic [31:0] ptr);
    int k, s, p;
    k = NIL;
    if (ptr == 0) return ST_OK;
    for (int i = 0; i < NCHUNK; i++) begin
      if (blk_used[i] && blk_base[i][31:1] == ptr[31:1]) begin
        k = i;
        break;
      end
    end
    if (k == NIL) return ST_NOT_FOUND;
    if (blk_avail[k]) return ST_ALREADY_FREE;
    avail_next[k] = avail_head;
    avail_head = k;
    blk_avail[k] = 1'b1;
    // Merge with a free successor, then with a free predecessor.
    s = hi_nbr[k];
    if (s < NIL && blk_avail[s]) begin
      blk_size[k] = blk_size[k] + blk_size[s];
      unlink_avail(s);
      drop_block(s);
    end
    p = lo_nbr[k];
    if (p < NIL && blk_avail[p]) begin
      blk_size[p] = blk_size[p] + blk_size[k];
      unlink_avail(k);
      drop_block(k);
    end
    return ST_OK;
  endfunction

  function automatic rsp_t predict_outcome(req_t r);
    rsp_t o;
    logic [31:0] a;
    o = '0;
    case (r.op)
      OP_INIT: o.status = carve_region();
      OP_ALLOC: begin
        o.status = grant_block(r.request_size, a);
        o.granted_address = a;
      end
      OP_FREE: o.status = release_block(r.release_address);
      default: o = '0;
    endcase
    return o;
  endfunction

  // Start address of a random chunk; busy only, or any chunk in the table.
  function automatic logic [31:0] pick_chunk(bit any_state);
    int cand [$];
    for (int i = 0; i < NCHUNK; i++)
      if (blk_used[i] && (any_state || !blk_avail[i])) cand.push_back(i);
    if (cand.size() == 0) return $urandom();
    return blk_base[cand[$urandom_range(0, cand.size() - 1)]];
  endfunction

  // Register write; the caller makes sure the block is idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_AREA_START: reg_start = val;
      CFG_AREA_LENGTH: reg_length = val;
      default: reg_align = val[15:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Offer one request transaction; returns at the next falling edge with valid still high.
  task automatic offer(req_t r, bit typed, rsp_t typed_rsp);
    rsp_t p;
    in_valid_i = 1'b1;
    in_data_i = r;
    do @(posedge clk_i); while (!in_ready_o);
    p = predict_outcome(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
    @(negedge clk_i);
  endtask

  // Sender bursts with random gaps between them.
  int burst_left = 0;
  bit no_gaps = 1'b0;
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    if (!no_gaps) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    burst_left = $urandom_range(1, 8);
  endtask

  // Receiver stalls on a rotating pattern.
  int rx_cnt = 0;
  always @(negedge clk_i) begin
    rx_cnt++;
    case ((rx_cnt / 97) % 4)
      0: out_ready_i = 1'b1;
      1: out_ready_i = $urandom_range(0, 1);
      2: out_ready_i = (rx_cnt % 4) == 0;
      default: out_ready_i = $urandom_range(0, 3) != 0;
    endcase
  end

  // Compare every response transaction with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected response: addr=%h status=%0d",
                   out_data_o.granted_address, out_data_o.status);
      end else begin
        e = pending_rsp.pop_front();
        if (out_data_o.granted_address !== e.granted_address ||
            out_data_o.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                     e.granted_address, e.status,
                     out_data_o.granted_address, out_data_o.status);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          val;
    req_t                 req;
    bit                   typed;
    rsp_t                 rsp;
  } step_t;

  step_t script [$];

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    step_t s;
    s = '{1'b1, idx, val, '0, 1'b0, '0};
    script.push_back(s);
  endfunction

  function automatic void add_req(logic [1:0] op, logic [31:0] sz, logic [31:0] ad,
                                  bit typed, logic [31:0] ga, logic [2:0] st);
    step_t s;
    s = '{1'b0, CFG_AREA_START, '0, '{op, sz, ad}, typed, '{ga, st}};
    script.push_back(s);
  endfunction

  initial begin
    req_t r;
    logic [31:0] a;
    int pick;

    reg_start = '0;
    reg_length = '0;
    reg_align = 16'd2;
    grain = 32'd2;
    wipe_table();

    // Directed steps: empty allocator, special cases and field extremes.
    add_req(OP_ALLOC, 32'd16, '0, 1, '0, ST_NO_MEMORY);
    add_req(OP_FREE, '0, 32'h100, 1, '0, ST_NOT_FOUND);
    add_req(OP_FREE, '0, '0, 1, '0, ST_OK);
    add_req(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, '0, ST_OK);
    add_req(OP_INIT, '0, '0, 1, '0, ST_INVALID_AREA);
    add_reg(CFG_AREA_START, 32'h1000);
    add_reg(CFG_AREA_LENGTH, 32'h1000);
    add_reg(CFG_ALIGN_UNIT, 32'd0);
    add_req(OP_INIT, '0, '0, 1, '0, ST_OK);
    add_req(OP_ALLOC, '0, '0, 1, '0, ST_NO_MEMORY);
    add_req(OP_ALLOC, 32'hFFFF_FFFF, '0, 1, '0, ST_NO_MEMORY);
    add_req(OP_ALLOC, 32'd1, '0, 0, '0, ST_OK);
    add_req(OP_ALLOC, 32'h1000, '0, 1, '0, ST_NO_MEMORY);
    add_req(OP_FREE, '0, 32'h1FFF, 0, '0, ST_OK);
    add_req(OP_FREE, '0, 32'h1FFE, 0, '0, ST_OK);
    add_req(OP_ALLOC, 32'h1000, '0, 0, '0, ST_OK);
    add_req(OP_FREE, '0, 32'h1000, 0, '0, ST_OK);
    add_req(OP_FREE, '0, 32'h1000, 1, '0, ST_ALREADY_FREE);
    add_reg(CFG_AREA_START, 32'hFFFF_FFFF);
    add_reg(CFG_AREA_LENGTH, 32'hFFFF_FFFF);
    add_reg(CFG_ALIGN_UNIT, 32'hFFFF);
    add_req(OP_INIT, '0, '0, 1, '0, ST_INVALID_AREA);
    add_reg(CFG_AREA_START, '0);
    add_reg(CFG_ALIGN_UNIT, 32'd1);
    add_req(OP_INIT, '0, '0, 0, '0, ST_OK);
    add_req(OP_ALLOC, 32'h7FFF_FFFF, '0, 0, '0, ST_OK);
    add_req(OP_ALLOC, 32'hFFFF_FFF0, '0, 1, '0, ST_NO_MEMORY);
    add_req(OP_ALLOC, 32'd3, '0, 0, '0, ST_OK);

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        drain();
        write_reg(script[i].idx, script[i].val);
      end else begin
        pace();
        offer(script[i].req, script[i].typed, script[i].rsp);
      end
    end

    // Random phases, each under its own region and alignment.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      no_gaps = (ph % 3) == 2;
      case (ph)
        3: begin
          write_reg(CFG_AREA_START, 32'h1000_0001);
          write_reg(CFG_AREA_LENGTH, 32'hEFFF_FFFF);
          write_reg(CFG_ALIGN_UNIT, 32'hFFFF);
        end
        5: begin
          write_reg(CFG_AREA_START, 32'hFFFF_0000);
          write_reg(CFG_AREA_LENGTH, 32'h0001_0000);
          write_reg(CFG_ALIGN_UNIT, 32'd4);
        end
        default: begin
          write_reg(CFG_AREA_START, $urandom());
          write_reg(CFG_AREA_LENGTH, $urandom_range(64, 4096));
          write_reg(CFG_ALIGN_UNIT, $urandom_range(0, 3) == 0 ?
                    $urandom_range(0, 65535) : $urandom_range(0, 16));
        end
      endcase
      r = '{OP_INIT, $urandom(), $urandom()};
      pace();
      offer(r, 1'b0, '0);
      for (int n = 0; n < 60; n++) begin
        pick = $urandom_range(0, 99);
        r = '{OP_ALLOC, $urandom(), $urandom()};
        if (pick < 50) begin
          case ($urandom_range(0, 9))
            0: r.request_size = '0;
            1: r.request_size = $urandom();
            2: r.request_size = $urandom_range(1, reg_length);
            default: r.request_size = $urandom_range(1, 3 * grain + 64);
          endcase
        end else if (pick < 82) begin
          r.op = OP_FREE;
          r.release_address = pick_chunk(1'b0);
        end else if (pick < 88) begin
          r.op = OP_FREE;
          a = pick_chunk(1'b1);
          r.release_address = a ^ {31'd0, pick[0]};
        end else if (pick < 94) begin
          r.op = OP_FREE;
          if (pick == 93) r.release_address = '0;
        end else if (pick < 97) begin
          r.op = 2'd3;
        end else begin
          r.op = OP_INIT;
        end
        pace();
        offer(r, 1'b0, '0);
      end
    end

    // Let the last responses arrive, then a little longer.
    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- first_fit_coalescing_allocator_core.f -----
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_rem.sv
hw/rtl/ffca_mem.sv
hw/rtl/first_fit_coalescing_allocator_core.sv
tb/tb.sv
